// ===== sv/fhs_pkg.sv =====
// ----------------------------------------------------------------------------
// fhs_pkg: shared types and constants for the flame heat buffer
// Field widths, command codes, heat limits and the queue word that passes
// from the front end to the execution back end.
// ----------------------------------------------------------------------------
package fhs_pkg;

   // field widths
   localparam int IDX_W  = 14;
   localparam int HEAT_W = 6;
   localparam int CMD_W  = 2;
   localparam int PICK_W = 2;

   // default buffer geometry
   localparam int WIDTH_DEF  = 128;
   localparam int HEIGHT_DEF = 128;

   // depth of the front-to-back queue
   localparam int QUEUE_DEPTH = 2;

   // heat limits
   localparam logic [HEAT_W-1:0] HEAT_MAX     = 6'd32;
   localparam logic [HEAT_W-1:0] IGNITE_RESET = 6'd22;

   // command codes
   localparam logic [CMD_W-1:0] CMD_IGNITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SPREAD = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;   // ignored by the block

   // one decoded operation, as queued for the back end
   typedef struct packed {
      logic [CMD_W-1:0]  op;       // CMD_IGNITE, CMD_SPREAD or CMD_READ
      logic [IDX_W-1:0]  rd_addr;  // source cell for spread and read
      logic              rd_ok;    // source lies inside the buffer
      logic [IDX_W-1:0]  wr_addr;  // target cell for ignite and spread
      logic              wr_ok;    // target lies inside the allowed range
      logic [HEAT_W-1:0] wr_heat;  // saturated ignite heat
      logic              decay;    // spread decay, pick AND 1
   } fhs_entry_type;

endpackage

// ===== sv/fhs_front.sv =====
// ----------------------------------------------------------------------------
// fhs_front: request decode
// Holds the ignite heat register, checks index ranges, works out the spread
// target cell and turns each accepted word, bar CMD_NONE, into a queue entry.
// ----------------------------------------------------------------------------
module fhs_front
   import fhs_pkg::*;
#(
   parameter int WIDTH = WIDTH_DEF,
   parameter int DEPTH = WIDTH_DEF * HEIGHT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [HEAT_W-1:0]   csr_wr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [IDX_W-1:0]    req_pixel_index,
   input  logic [PICK_W-1:0]   req_rand_pick,
   input  logic                queue_full,
   input  logic                clear_busy,
   output logic                push_valid,
   output fhs_entry_type       push_entry
);

   localparam logic [IDX_W:0]   DEPTH_V = (IDX_W+1)'(DEPTH);
   localparam logic [IDX_W+1:0] WIDTH_V = (IDX_W+2)'(WIDTH);

   logic [HEAT_W-1:0]        ignite_heat_ff;
   logic [HEAT_W-1:0]        ignite_heat_in;
   logic [HEAT_W-1:0]        ignite_sat;
   logic                     src_ok;
   logic signed [IDX_W+1:0]  dst;
   logic                     dst_ok;

   // ignite heat register
   assign ignite_heat_in = csr_wr_en ? csr_wr_data : ignite_heat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ignite_heat_ff <= IGNITE_RESET;
      end else begin
         ignite_heat_ff <= ignite_heat_in;
      end
   end

   assign ignite_sat = (ignite_heat_ff > HEAT_MAX) ? HEAT_MAX : ignite_heat_ff;

   // range checks and spread target: one row up, drift of one minus pick
   assign src_ok = {1'b0, req_pixel_index} < DEPTH_V;
   assign dst    = $signed({2'b00, req_pixel_index}) + $signed((IDX_W+2)'(1))
                 - $signed({{IDX_W{1'b0}}, req_rand_pick}) - $signed(WIDTH_V);
   assign dst_ok = !dst[IDX_W+1] && (dst != '0) && (dst[IDX_W:0] < DEPTH_V);

   // handshake: hold off while the queue is full or the buffer is clearing
   assign req_stall  = queue_full || clear_busy;
   assign push_valid = req_valid && !req_stall && (req_cmd != CMD_NONE);

   // build the queue word
   always_comb begin
      push_entry         = '0;
      push_entry.op      = req_cmd;
      push_entry.wr_heat = ignite_sat;
      push_entry.decay   = req_rand_pick[0];
      case (req_cmd)
         CMD_IGNITE: begin
            push_entry.wr_addr = req_pixel_index;
            push_entry.wr_ok   = src_ok;
         end
         CMD_SPREAD: begin
            push_entry.rd_addr = req_pixel_index;
            push_entry.rd_ok   = src_ok;
            push_entry.wr_addr = dst[IDX_W-1:0];
            push_entry.wr_ok   = dst_ok;
         end
         CMD_READ: begin
            push_entry.rd_addr = req_pixel_index;
            push_entry.rd_ok   = src_ok;
         end
         default: begin
            push_entry.op = CMD_READ;
         end
      endcase
   end

endmodule

// ===== sv/fhs_queue.sv =====
// ----------------------------------------------------------------------------
// fhs_queue: short FIFO between decode and execution
// Lets the front end take requests while the back end is busy or stalled.
// ----------------------------------------------------------------------------
module fhs_queue
   import fhs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  fhs_entry_type  push_entry,
   output logic           full,
   input  logic           pop,
   output logic           pop_valid,
   output fhs_entry_type  pop_entry
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_V = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_V = PTR_W'(QUEUE_DEPTH - 1);

   fhs_entry_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == FULL_V);
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_V) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_V) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef ASSERT_OFF
   // the front end never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("queue push while full");
`endif

endmodule

// ===== sv/fhs_back.sv =====
// ----------------------------------------------------------------------------
// fhs_back: heat buffer and execution
// Owns the heat memory, clears it after reset, and carries out ignite,
// spread and read entries one at a time: read cycle, then write or reply.
// ----------------------------------------------------------------------------
module fhs_back
   import fhs_pkg::*;
#(
   parameter int DEPTH  = WIDTH_DEF * HEIGHT_DEF,
   parameter int ADDR_W = $clog2(WIDTH_DEF * HEIGHT_DEF)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  fhs_entry_type       q_entry,
   output logic                q_pop,
   output logic                clear_busy,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [HEAT_W-1:0]   rsp_heat
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   logic [HEAT_W-1:0]  heat_mem [DEPTH];

   logic [1:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   fhs_entry_type      exec_ff, exec_in;
   logic [HEAT_W-1:0]  rd_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [HEAT_W-1:0]  rsp_heat_ff, rsp_heat_in;

   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic [HEAT_W-1:0]  mem_wr_data;
   logic [HEAT_W-1:0]  src_heat;
   logic [HEAT_W-1:0]  spread_heat;
   logic               is_read;
   logic               exec_done;

   assign clear_busy = (state_ff == ST_CLEAR);
   assign q_pop      = (state_ff == ST_IDLE) && q_valid;
   assign is_read    = (exec_ff.op == CMD_READ);
   assign exec_done  = (state_ff == ST_EXEC) && (!is_read || !rsp_valid_ff || !rsp_stall);

   // source heat, decay and clamp
   assign src_heat    = exec_ff.rd_ok ? rd_data_ff : '0;
   assign spread_heat = (src_heat > HEAT_MAX) ? HEAT_MAX :
                        (src_heat == '0) ? '0 : src_heat - HEAT_W'(exec_ff.decay);

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      exec_in  = exec_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               exec_in  = q_entry;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      exec_ff <= exec_in;
   end

   // memory write port: clearing pass, ignite or spread
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = exec_ff.wr_addr[ADDR_W-1:0];
      mem_wr_data = (exec_ff.op == CMD_IGNITE) ? exec_ff.wr_heat : spread_heat;
      if (state_ff == ST_CLEAR) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_ff;
         mem_wr_data = '0;
      end else if ((state_ff == ST_EXEC) && !is_read && exec_ff.wr_ok) begin
         mem_wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         heat_mem[mem_wr_addr] <= mem_wr_data;
      end
   end

   // memory read port, registered
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_data_ff <= heat_mem[q_entry.rd_addr[ADDR_W-1:0]];
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_heat_in  = rsp_heat_ff;
      if (exec_done && is_read) begin
         rsp_valid_in = 1'b1;
         rsp_heat_in  = src_heat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_heat_ff <= rsp_heat_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_heat  = rsp_heat_ff;

`ifndef ASSERT_OFF
   // nothing leaves the queue while the buffer is being cleared
   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !q_pop)
      else $error("queue popped during clearing pass");

   // a finished read always shows up on the response port
   a_read_replies: assert property (@(posedge clock) disable iff (reset)
      (exec_done && is_read) |=> rsp_valid_ff)
      else $error("read finished without a response");

   // returned heat stays within its range
   a_heat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_heat_ff <= HEAT_MAX))
      else $error("response heat out of range");
`endif

endmodule

// ===== sv/fire_effect_heat_spread.sv =====
// ----------------------------------------------------------------------------
// fire_effect_heat_spread: flame effect heat buffer
// Row-major heat buffer with ignite, spread and read requests.
// ----------------------------------------------------------------------------
// Usage:
//   Request words (req_cmd, req_pixel_index, req_rand_pick) are taken when
//   req_valid is high and req_stall is low. Ignite writes the ignite heat
//   register (csr_wr_en / csr_wr_data) into a cell, spread moves a decayed
//   copy of a cell one row up with drift, read returns a cell's heat on
//   rsp_heat with rsp_valid; only reads give a response word.
//   In the execution unit each word goes through a registered memory read,
//   then a write or reply, and the unit finishes one word before it takes
//   the next. With an empty queue a read reply passes through the queue,
//   the registered memory read and the response register.
//   A two-entry queue sits between decode and execution, so requests keep
//   flowing while a reply waits on rsp_stall; once the queue fills,
//   req_stall rises. A held reply keeps rsp_heat stable.
//   After reset the heat memory is cleared one cell per cycle, all DEPTH
//   cells (16384 at the default 128 by 128) with req_stall high meanwhile;
//   the ignite heat register resets to 22 and accepts writes at any time.
// ----------------------------------------------------------------------------
module fire_effect_heat_spread
   import fhs_pkg::*;
#(
   parameter int WIDTH  = WIDTH_DEF,
   parameter int HEIGHT = HEIGHT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [HEAT_W-1:0]   csr_wr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [IDX_W-1:0]    req_pixel_index,
   input  logic [PICK_W-1:0]   req_rand_pick,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [HEAT_W-1:0]   rsp_heat
);

   // cells reachable through a 14-bit index
   localparam int CELLS  = WIDTH * HEIGHT;
   localparam int DEPTH  = (CELLS < (1 << IDX_W)) ? CELLS : (1 << IDX_W);
   localparam int ADDR_W = $clog2(DEPTH);

   fhs_entry_type  push_entry;
   fhs_entry_type  pop_entry;
   logic           push_valid;
   logic           queue_full;
   logic           pop_valid;
   logic           q_pop;
   logic           clear_busy;

   // decode
   fhs_front #(
      .WIDTH (WIDTH),
      .DEPTH (DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_pixel_index (req_pixel_index),
      .req_rand_pick   (req_rand_pick),
      .queue_full      (queue_full),
      .clear_busy      (clear_busy),
      .push_valid      (push_valid),
      .push_entry      (push_entry)
   );

   // decoupling queue
   fhs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (q_pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   // execution and heat memory
   fhs_back #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (pop_valid),
      .q_entry    (pop_entry),
      .q_pop      (q_pop),
      .clear_busy (clear_busy),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_heat   (rsp_heat)
   );

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the flame effect heat buffer
// Drives ignite, spread and read words into fire_effect_heat_spread with
// random idling on both channels. A shadow copy of the heat buffer predicts
// each read reply, and every reply word is checked in order against it.
// ----------------------------------------------------------------------------
module tb;
   import fhs_pkg::*;

   localparam int ROW_W      = WIDTH_DEF;
   localparam int NUM_CELLS  = WIDTH_DEF * HEIGHT_DEF;
   localparam int IDLE_PCT   = 13;
   localparam int SETTLE_CYC = 16;      // covers the queue of two and the execution unit
   localparam int HANG_LIMIT = 50000;   // covers the clear pass after reset
   localparam int SHOW_MAX   = 10;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [HEAT_W-1:0]   csr_wr_data;
   logic                req_valid;
   logic                req_stall;
   logic [CMD_W-1:0]    req_cmd;
   logic [IDX_W-1:0]    req_pixel_index;
   logic [PICK_W-1:0]   req_rand_pick;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [HEAT_W-1:0]   rsp_heat;

   logic                quiet;        // no idling on either side
   int                  hang_count;

   // shadow heat buffer and the replies it predicts
   class flame_model;
      logic [HEAT_W-1:0] heat_map [NUM_CELLS];
      logic [HEAT_W-1:0] ignite_heat;
      logic [HEAT_W-1:0] pending_heat [$];
      int unsigned       faults;

      function new();
         foreach (heat_map[i])
            heat_map[i] = '0;
         ignite_heat = IGNITE_RESET;
         faults = 0;
      endfunction

      function void set_ignite(input logic [HEAT_W-1:0] value);
         ignite_heat = value;
      endfunction

      // apply one accepted request word
      function void take_request(input logic [CMD_W-1:0] cmd,
                                 input logic [IDX_W-1:0] pixel,
                                 input logic [PICK_W-1:0] pick);
         int src;
         int val;
         int dst;
         src = int'(pixel);
         case (cmd)
            CMD_IGNITE: begin
               if (src < NUM_CELLS)
                  heat_map[src] = (ignite_heat > HEAT_MAX) ? HEAT_MAX : ignite_heat;
            end
            CMD_SPREAD: begin
               val = (src < NUM_CELLS) ? int'(heat_map[src]) : 0;
               val = val - int'(pick[0]);
               if (val > int'(HEAT_MAX))
                  val = int'(HEAT_MAX);
               if (val < 0)
                  val = 0;
               // one row up, drift of 1 - pick
               dst = src - int'(pick) + 1 - ROW_W;
               if (dst > 0 && dst < NUM_CELLS)
                  heat_map[dst] = val[HEAT_W-1:0];
            end
            CMD_READ: begin
               pending_heat.push_back((src < NUM_CELLS) ? heat_map[src] : '0);
            end
            default: ;
         endcase
      endfunction

      // compare one reply word with the oldest prediction
      function void check_reply(input logic [HEAT_W-1:0] heat);
         logic [HEAT_W-1:0] want;
         if (pending_heat.size() == 0) begin
            faults++;
            if (faults <= SHOW_MAX)
               $display("unexpected reply word: heat %0d", heat);
         end else begin
            want = pending_heat.pop_front();
            if (heat !== want) begin
               faults++;
               if (faults <= SHOW_MAX)
                  $display("heat mismatch: expected %0d, got %0d", want, heat);
            end
         end
      endfunction
   endclass

   flame_model model;

   fire_effect_heat_spread #(
      .WIDTH (WIDTH_DEF),
      .HEIGHT(HEIGHT_DEF)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_pixel_index(req_pixel_index),
      .req_rand_pick  (req_rand_pick),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_heat       (rsp_heat)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
   end

   // reply checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         model.check_reply(rsp_heat);
   end

   // hang detector: cycles with no word moving on either channel
   initial begin
      hang_count = 0;
      while (hang_count < HANG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            hang_count = 0;
         else
            hang_count++;
      end
      $display("FAILURE");
      $finish;
   end

   // send one request word and wait until it is taken
   task automatic send_word(input logic [CMD_W-1:0] cmd, input int pixel, input int pick);
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_pixel_index <= pixel[IDX_W-1:0];
      req_rand_pick   <= pick[PICK_W-1:0];
      do
         @(posedge clock);
      while (req_stall);
      model.take_request(cmd, pixel[IDX_W-1:0], pick[PICK_W-1:0]);
   endtask

   // let all replies arrive and the execution unit drain
   task automatic settle();
      req_valid <= 1'b0;
      while (model.pending_heat.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_ignite(input logic [HEAT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      model.set_ignite(value);
   endtask

   // random flames: ignite a cell, spread upward in a chain, read along the
   // way; the rest is noise over the whole buffer
   task automatic run_flames(input int count);
      int sent;
      int pixel;
      int pick;
      int steps;
      logic [CMD_W-1:0] cmd;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 75) begin
            pixel = $urandom_range(1, HEIGHT_DEF - 1) * ROW_W + $urandom_range(0, ROW_W - 1);
            if ($urandom_range(0, 9) < 7) begin
               send_word(CMD_IGNITE, pixel, $urandom_range(0, 3));
               sent++;
            end
            steps = $urandom_range(1, 6);
            repeat (steps) begin
               pick = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
               send_word(CMD_SPREAD, pixel, pick);
               sent++;
               pixel = pixel - pick + 1 - ROW_W;
               if (pixel <= 0)
                  break;
               if ($urandom_range(0, 9) < 6) begin
                  send_word(CMD_READ, pixel, $urandom_range(0, 3));
                  sent++;
               end
            end
         end else begin
            cmd = CMD_W'($urandom_range(0, 3));
            send_word(cmd, $urandom_range(0, NUM_CELLS - 1), $urandom_range(0, 3));
            if (cmd != CMD_NONE)
               sent++;
         end
      end
   endtask

   initial begin
      logic [HEAT_W-1:0] levels [6];
      model           = new();
      quiet           = 1'b0;
      reset           <= 1'b1;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= '0;
      req_valid       <= 1'b0;
      req_cmd         <= CMD_IGNITE;
      req_pixel_index <= '0;
      req_rand_pick   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset contents and reset ignite heat, corner cells
      send_word(CMD_READ, 0, 0);
      send_word(CMD_READ, NUM_CELLS - 1, 3);
      send_word(CMD_IGNITE, NUM_CELLS - 1, 0);
      send_word(CMD_READ, NUM_CELLS - 1, 0);
      send_word(CMD_IGNITE, 0, 0);
      send_word(CMD_READ, 0, 0);
      // every pick from the bottom-right cell
      send_word(CMD_SPREAD, NUM_CELLS - 1, 0);
      send_word(CMD_SPREAD, NUM_CELLS - 1, 1);
      send_word(CMD_SPREAD, NUM_CELLS - 1, 2);
      send_word(CMD_SPREAD, NUM_CELLS - 1, 3);
      send_word(CMD_READ, NUM_CELLS - 1 - ROW_W + 1, 0);
      send_word(CMD_READ, NUM_CELLS - 1 - ROW_W, 0);
      send_word(CMD_READ, NUM_CELLS - 1 - ROW_W - 1, 0);
      send_word(CMD_READ, NUM_CELLS - 1 - ROW_W - 2, 0);
      // destination at cell 0 or below is dropped, cell 1 is written
      send_word(CMD_SPREAD, ROW_W - 1, 0);
      send_word(CMD_SPREAD, 0, 3);
      send_word(CMD_IGNITE, ROW_W, 0);
      send_word(CMD_SPREAD, ROW_W, 0);
      send_word(CMD_NONE, 0, 0);
      send_word(CMD_READ, 0, 0);
      send_word(CMD_READ, 1, 0);
      settle();

      // ignite heat above the limit saturates
      write_ignite(6'd63);
      send_word(CMD_IGNITE, 16000, 0);
      send_word(CMD_SPREAD, 16000, 0);
      send_word(CMD_READ, 16000 - ROW_W + 1, 0);
      settle();

      // zero heat with decay clamps at zero
      write_ignite(6'd0);
      send_word(CMD_IGNITE, 16000, 0);
      send_word(CMD_SPREAD, 16000, 1);
      send_word(CMD_READ, 16000 - ROW_W, 0);
      settle();

      levels[0] = HEAT_MAX;
      levels[1] = 6'd1;
      levels[2] = 6'd33;
      levels[3] = IGNITE_RESET;
      levels[4] = HEAT_W'($urandom_range(0, 63));
      levels[5] = HEAT_W'($urandom_range(0, 32));
      foreach (levels[k]) begin
         write_ignite(levels[k]);
         quiet = (k == 2);
         run_flames(200);
         settle();
      end

      if (model.faults == 0 && model.pending_heat.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
